// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, operation and status codes and the CORDIC angle table of
// the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  // Extra fraction bits carried through the CORDIC datapath.
  localparam int GUARD_BITS = 8;
  // Reciprocal of the CORDIC gain in Q20.
  localparam logic [19:0] INV_GAIN_Q20 = 20'd636752;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_CONJ  = 3'd4;
  localparam logic [2:0] OP_POLAR = 3'd5;
  localparam logic [2:0] OP_CMP   = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // atan(2^-i) as a binary angle, 2^32 being one full turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/cau_div_step.sv =====
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring division step for the real and imaginary lanes,
// which share the denominator.
// ----------------------------------------------------------------------------
module cau_div_step #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [2*DATA_WIDTH-1:0]     den_i,
  input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_re_i,
  input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_im_i,
  input  logic [DATA_WIDTH+1:0]       quo_re_i,
  input  logic [DATA_WIDTH+1:0]       quo_im_i,
  output logic [2*DATA_WIDTH-1:0]     den_o,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_re_o,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_im_o,
  output logic [DATA_WIDTH+1:0]       quo_re_o,
  output logic [DATA_WIDTH+1:0]       quo_im_o
);

  localparam int RW = 2*DATA_WIDTH + FRAC_BITS;
  localparam int CW = 3*DATA_WIDTH + FRAC_BITS + 2;

  logic [CW-1:0] dsh;
  logic [CW-1:0] dif_re, dif_im;
  logic          ge_re, ge_im;
  logic [2*DATA_WIDTH-1:0] den_q;
  logic [RW-1:0] rem_re_q, rem_im_q;
  logic [DATA_WIDTH+1:0] quo_re_q, quo_im_q, quo_re_d, quo_im_d;

  assign dsh    = CW'(den_i) << SHIFT;
  assign ge_re  = CW'(rem_re_i) >= dsh;
  assign ge_im  = CW'(rem_im_i) >= dsh;
  assign dif_re = CW'(rem_re_i) - dsh;
  assign dif_im = CW'(rem_im_i) - dsh;

  always_comb begin
    quo_re_d        = quo_re_i;
    quo_im_d        = quo_im_i;
    quo_re_d[SHIFT] = ge_re;
    quo_im_d[SHIFT] = ge_im;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q    <= den_i;
      rem_re_q <= ge_re ? dif_re[RW-1:0] : rem_re_i;
      rem_im_q <= ge_im ? dif_im[RW-1:0] : rem_im_i;
      quo_re_q <= quo_re_d;
      quo_im_q <= quo_im_d;
    end
  end

  assign den_o    = den_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign quo_re_o = quo_re_q;
  assign quo_im_o = quo_im_q;

endmodule

// ===== hdl/cau_cordic_step.sv =====
// ----------------------------------------------------------------------------
// cau_cordic_step
// One registered vectoring CORDIC micro-rotation with its angle accumulator.
// ----------------------------------------------------------------------------
module cau_cordic_step #(
  parameter int XW   = cau_pkg::DATA_WIDTH_DEF + cau_pkg::GUARD_BITS + 3,
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [31:0]          z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [31:0]          z_o
);

  logic signed [XW-1:0] dx, dy;
  logic [31:0]          ang;
  logic signed [XW-1:0] x_q, y_q;
  logic [31:0]          z_q;

  // Arithmetic shifts floor towards minus infinity, as the rotation needs.
  assign dx  = y_i >>> STEP;
  assign dy  = x_i >>> STEP;
  assign ang = cau_pkg::atan_turn(5'(STEP));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!y_i[XW-1]) begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + ang;
      end else begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - ang;
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== hdl/complex_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Every operation takes the same path through the pipeline, whose division and
// CORDIC chain is sized by CHAIN = max(DATA_WIDTH + 2, CORDIC_STEPS).
// Throughput: one transaction per cycle while the output is not stalled; the divider
// takes one quotient bit per stage and the CORDIC one micro-rotation per stage.
// Reset clears the valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH   = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF,
  localparam int IN_TW  = ((3 + 4*DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((2*DATA_WIDTH + 5 + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // From bit 0 up: op (3), a_re, a_im, b_re, b_im (DATA_WIDTH each), zero pad.
  input  logic [IN_TW-1:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // From bit 0 up: res_re, res_im (DATA_WIDTH each), status (2), order (2),
  // same_value (1), zero pad.
  output logic [OUT_TW-1:0] m_axis_tdata_o
);

  localparam int W         = DATA_WIDTH;
  localparam int F         = FRAC_BITS;
  localparam int N         = CORDIC_STEPS;
  localparam int DIV_STEPS = W + 2;
  localparam int CHAIN     = (DIV_STEPS > N) ? DIV_STEPS : N;
  localparam int NST       = CHAIN + 4;
  localparam int RW        = 2*W + F;
  localparam int QW        = W + 2;
  localparam int XW        = W + cau_pkg::GUARD_BITS + 3;
  localparam int MW        = 2*W + 2;
  localparam int PW        = XW - 1 + 20;
  localparam int MAG_SH    = cau_pkg::GUARD_BITS + 20;
  // Side word: op, fast re, fast im, status, order, same, two signs, b zero,
  // a zero.
  localparam int SW        = 3 + 2*W + 2 + 2 + 1 + 2 + 1 + 1;

  localparam logic [MW-1:0] HALF    = MW'(1) << (W-1);
  localparam logic [MW-1:0] RND     = (F > 0) ? (MW'(1) << ((F > 0) ? F-1 : 0)) : '0;
  localparam logic [W-1:0]  SMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  SMIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] MAG_RND = PW'(1) << (MAG_SH - 1);

  // Sign and magnitude to a saturated signed word; the top bit flags saturation.
  function automatic logic [W:0] fin(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] nm;
    logic [W:0]    r;
    nm = ~mag + MW'(1);
    if (neg) begin
      if (mag > HALF) r = {1'b1, SMIN};
      else            r = {1'b0, nm[W-1:0]};
    end else begin
      if (mag > HALF - MW'(1)) r = {1'b1, SMAX};
      else                     r = {1'b0, mag[W-1:0]};
    end
    return r;
  endfunction

  // One-bit-wider signed sum to a saturated word; the top bit flags saturation.
  function automatic logic [W:0] sat1(input logic [W:0] v);
    logic [W:0] r;
    if (v[W] != v[W-1]) r = {1'b1, v[W] ? SMIN : SMAX};
    else                r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake. The whole pipeline moves when the output register is free or
  // being emptied; a stall freezes every stage, so nothing is lost or doubled.
  // --------------------------------------------------------------------------
  logic en;
  logic v_q [NST];

  assign en              = !v_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NST; k++) v_q[k] <= v_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: operand registers and all eight partial products.
  // --------------------------------------------------------------------------
  logic [2:0]            in_op;
  logic signed [W-1:0]   in_ar, in_ai, in_br, in_bi;

  assign in_op = s_axis_tdata_i[2:0];
  assign in_ar = s_axis_tdata_i[3 +: W];
  assign in_ai = s_axis_tdata_i[3+W +: W];
  assign in_br = s_axis_tdata_i[3+2*W +: W];
  assign in_bi = s_axis_tdata_i[3+3*W +: W];

  logic [2:0]            op1_q;
  logic signed [W-1:0]   ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [2*W-1:0] prr1_q, pii1_q, pri1_q, pir1_q;
  logic signed [2*W-1:0] paar1_q, paai1_q, pbbr1_q, pbbi1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q   <= in_op;
      ar1_q   <= in_ar;
      ai1_q   <= in_ai;
      br1_q   <= in_br;
      bi1_q   <= in_bi;
      prr1_q  <= in_ar * in_br;
      pii1_q  <= in_ai * in_bi;
      pri1_q  <= in_ar * in_bi;
      pir1_q  <= in_ai * in_br;
      paar1_q <= in_ar * in_ar;
      paai1_q <= in_ai * in_ai;
      pbbr1_q <= in_br * in_br;
      pbbi1_q <= in_bi * in_bi;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the short operations finish here (add, subtract, multiply,
  // conjugate, compare). Division and polar form are set up for their chains.
  // --------------------------------------------------------------------------
  logic signed [2*W:0] mre_s, mim_s, nre_s, nim_s;
  logic [2*W:0]        mre_m, mim_m, nre_m, nim_m;
  logic [2*W:0]        ma, mb;
  logic [2*W-1:0]      den2;
  logic [W:0]          f_re, f_im;
  logic [1:0]          f_st, f_ord;
  logic                f_same;
  logic signed [XW-1:0] xi, yi;
  logic [31:0]         zi;

  assign mre_s = (2*W+1)'(prr1_q) - (2*W+1)'(pii1_q);
  assign mim_s = (2*W+1)'(pri1_q) + (2*W+1)'(pir1_q);
  assign nre_s = (2*W+1)'(prr1_q) + (2*W+1)'(pii1_q);
  assign nim_s = (2*W+1)'(pir1_q) - (2*W+1)'(pri1_q);
  assign mre_m = mre_s[2*W] ? -mre_s : mre_s;
  assign mim_m = mim_s[2*W] ? -mim_s : mim_s;
  assign nre_m = nre_s[2*W] ? -nre_s : nre_s;
  assign nim_m = nim_s[2*W] ? -nim_s : nim_s;
  assign ma    = (2*W+1)'($unsigned(paar1_q)) + (2*W+1)'($unsigned(paai1_q));
  assign mb    = (2*W+1)'($unsigned(pbbr1_q)) + (2*W+1)'($unsigned(pbbi1_q));
  assign den2  = $unsigned(pbbr1_q) + $unsigned(pbbi1_q);

  always_comb begin
    logic [W:0] t_re, t_im;
    t_re   = '0;
    t_im   = '0;
    f_ord  = cau_pkg::ORD_LT;
    f_same = 1'b0;
    case (op1_q)
      cau_pkg::OP_ADD: begin
        t_re = sat1((W+1)'(ar1_q) + (W+1)'(br1_q));
        t_im = sat1((W+1)'(ai1_q) + (W+1)'(bi1_q));
      end
      cau_pkg::OP_SUB: begin
        t_re = sat1((W+1)'(ar1_q) - (W+1)'(br1_q));
        t_im = sat1((W+1)'(ai1_q) - (W+1)'(bi1_q));
      end
      cau_pkg::OP_MUL: begin
        // Round half away from zero on the magnitude, then saturate.
        t_re = fin(mre_s[2*W], (MW'(mre_m) + RND) >> F);
        t_im = fin(mim_s[2*W], (MW'(mim_m) + RND) >> F);
      end
      cau_pkg::OP_CONJ: begin
        t_re = {1'b0, ar1_q};
        t_im = sat1(-((W+1)'(ai1_q)));
      end
      cau_pkg::OP_CMP: begin
        if (ma < mb)       f_ord = cau_pkg::ORD_LT;
        else if (ma == mb) f_ord = cau_pkg::ORD_EQ;
        else               f_ord = cau_pkg::ORD_GT;
        f_same = (ar1_q == br1_q) && (ai1_q == bi1_q);
      end
      default: begin
        t_re = '0;
        t_im = '0;
      end
    endcase
    f_re = t_re;
    f_im = t_im;
    f_st = (t_re[W] || t_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
  end

  // CORDIC start vector; a vector in the left half-plane is turned by pi.
  always_comb begin
    xi = XW'(ar1_q) <<< cau_pkg::GUARD_BITS;
    yi = XW'(ai1_q) <<< cau_pkg::GUARD_BITS;
    zi = 32'h0;
    if (ar1_q[W-1]) begin
      xi = -xi;
      yi = -yi;
      zi = 32'h8000_0000;
    end
  end

  // Chain arrays; index 0 is the stage 2 register.
  logic [SW-1:0]        side_q [CHAIN+1];
  logic [2*W-1:0]       den_c  [CHAIN+1];
  logic [RW-1:0]        rre_c  [CHAIN+1];
  logic [RW-1:0]        rim_c  [CHAIN+1];
  logic [QW-1:0]        qre_c  [CHAIN+1];
  logic [QW-1:0]        qim_c  [CHAIN+1];
  logic signed [XW-1:0] x_c    [CHAIN+1];
  logic signed [XW-1:0] y_c    [CHAIN+1];
  logic [31:0]          z_c    [CHAIN+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= {(ar1_q == '0) && (ai1_q == '0), den2 == '0, nim_s[2*W], nre_s[2*W],
                    f_same, f_ord, f_st, f_im[W-1:0], f_re[W-1:0], op1_q};
      for (int k = 1; k <= CHAIN; k++) side_q[k] <= side_q[k-1];
      den_c[0]  <= den2;
      rre_c[0]  <= RW'(nre_m) << F;
      rim_c[0]  <= RW'(nim_m) << F;
      qre_c[0]  <= '0;
      qim_c[0]  <= '0;
      x_c[0]    <= xi;
      y_c[0]    <= yi;
      z_c[0]    <= zi;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 .. CHAIN+2: restoring division, one quotient bit per stage from
  // weight 2^(W+1) down, and vectoring CORDIC, one micro-rotation per stage.
  // The shorter chain idles through plain registers to the common end.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < CHAIN; j++) begin : g_chain
    if (j < DIV_STEPS) begin : g_div
      cau_div_step #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (F),
        .SHIFT      (DIV_STEPS - 1 - j)
      ) u_div_step (
        .clk_i    (clk_i),
        .en_i     (en),
        .den_i    (den_c[j]),
        .rem_re_i (rre_c[j]),
        .rem_im_i (rim_c[j]),
        .quo_re_i (qre_c[j]),
        .quo_im_i (qim_c[j]),
        .den_o    (den_c[j+1]),
        .rem_re_o (rre_c[j+1]),
        .rem_im_o (rim_c[j+1]),
        .quo_re_o (qre_c[j+1]),
        .quo_im_o (qim_c[j+1])
      );
    end else begin : g_div_hold
      always_ff @(posedge clk_i) begin
        if (en) begin
          den_c[j+1] <= den_c[j];
          rre_c[j+1] <= rre_c[j];
          rim_c[j+1] <= rim_c[j];
          qre_c[j+1] <= qre_c[j];
          qim_c[j+1] <= qim_c[j];
        end
      end
    end

    if (j < N) begin : g_cordic
      cau_cordic_step #(
        .XW   (XW),
        .STEP (j)
      ) u_cordic_step (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (x_c[j]),
        .y_i   (y_c[j]),
        .z_i   (z_c[j]),
        .x_o   (x_c[j+1]),
        .y_o   (y_c[j+1]),
        .z_o   (z_c[j+1])
      );
    end else begin : g_cordic_hold
      always_ff @(posedge clk_i) begin
        if (en) begin
          x_c[j+1] <= x_c[j];
          y_c[j+1] <= y_c[j];
          z_c[j+1] <= z_c[j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage CHAIN+3: gain correction product, phase rounding and saturation of
  // the quotients.
  // --------------------------------------------------------------------------
  logic [XW-2:0]   xpos;
  logic [31:0]     z_end, z_rnd;
  logic [W-1:0]    ph_d;
  logic [PW-1:0]   prod_q;
  logic [W-1:0]    ph_q;
  logic [W:0]      dre_q, dim_q;
  logic [SW-1:0]   sidem_q;
  logic            nre_end, nim_end;

  assign xpos    = x_c[CHAIN][XW-1] ? '0 : x_c[CHAIN][XW-2:0];
  assign z_end   = z_c[CHAIN];
  assign nre_end = side_q[CHAIN][3+2*W+5];
  assign nim_end = side_q[CHAIN][3+2*W+6];

  // The phase is rounded half up to the output width and wraps.
  if (W < 32) begin : g_ph_rnd
    assign z_rnd = z_end + (32'(1) << (31 - W));
    assign ph_d  = z_rnd[31 -: W];
  end else begin : g_ph_full
    assign z_rnd = z_end;
    assign ph_d  = W'(z_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= PW'(xpos) * PW'(cau_pkg::INV_GAIN_Q20);
      ph_q    <= ph_d;
      dre_q   <= fin(nre_end, MW'(qre_c[CHAIN]));
      dim_q   <= fin(nim_end, MW'(qim_c[CHAIN]));
      sidem_q <= side_q[CHAIN];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: magnitude rounding and saturation, result selection.
  // --------------------------------------------------------------------------
  logic [2:0]    s_op;
  logic [W-1:0]  s_re, s_im;
  logic [1:0]    s_st, s_ord;
  logic          s_same, s_dz, s_az;
  logic [PW-1:0] mag_r;
  logic [W:0]    pol;
  logic [W-1:0]  o_re, o_im;
  logic [1:0]    o_st, o_ord;
  logic          o_same;
  logic [OUT_TW-1:0] tdata_q;

  assign s_op   = sidem_q[2:0];
  assign s_re   = sidem_q[3 +: W];
  assign s_im   = sidem_q[3+W +: W];
  assign s_st   = sidem_q[3+2*W +: 2];
  assign s_ord  = sidem_q[3+2*W+2 +: 2];
  assign s_same = sidem_q[3+2*W+4];
  assign s_dz   = sidem_q[3+2*W+7];
  assign s_az   = sidem_q[3+2*W+8];

  assign mag_r = prod_q + MAG_RND;
  assign pol   = fin(1'b0, MW'(mag_r[PW-1:MAG_SH]));

  always_comb begin
    o_re   = s_re;
    o_im   = s_im;
    o_st   = s_st;
    o_ord  = s_ord;
    o_same = s_same;
    case (s_op)
      cau_pkg::OP_DIV: begin
        if (s_dz) begin
          o_re = '0;
          o_im = '0;
          o_st = cau_pkg::ST_DIVZ;
        end else begin
          o_re = dre_q[W-1:0];
          o_im = dim_q[W-1:0];
          o_st = (dre_q[W] || dim_q[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::OP_POLAR: begin
        // A zero vector has no defined angle: report zero for both.
        if (s_az) begin
          o_re = '0;
          o_im = '0;
          o_st = cau_pkg::ST_OK;
        end else begin
          o_re = pol[W-1:0];
          o_im = ph_q;
          o_st = pol[W] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      default: begin
        o_re = s_re;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= OUT_TW'({o_same, o_ord, o_st, o_im, o_re});
    end
  end

  assign m_axis_tdata_o = tdata_q;

endmodule

// ===== hdl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  localparam int OUT_TW = ((2*DATA_WIDTH + 5 + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [OUT_TW-1:0] m_axis_tdata_o
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] c_re, c_im;
  logic [1:0]   c_st, c_ord;
  logic         c_same;

  assign c_re   = m_axis_tdata_o[W-1:0];
  assign c_im   = m_axis_tdata_o[2*W-1:W];
  assign c_st   = m_axis_tdata_o[2*W +: 2];
  assign c_ord  = m_axis_tdata_o[2*W+2 +: 2];
  assign c_same = m_axis_tdata_o[2*W+4];

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // The pipeline only takes a new transaction when it can also move on.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow the output stage");

  a_divz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && c_st == cau_pkg::ST_DIVZ |->
      c_re == '0 && c_im == '0 && c_ord == cau_pkg::ORD_LT && !c_same)
    else $error("division by zero result is not cleared");

  // Only a compare sets order or same_value, and a compare leaves the rest zero.
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (c_ord != cau_pkg::ORD_LT || c_same) |->
      c_st == cau_pkg::ST_OK && c_re == '0 && c_im == '0)
    else $error("compare result carries arithmetic fields");

endmodule

bind complex_arithmetic_unit_core cau_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for complex_arithmetic_unit_core. A queue of operand
// transactions feeds a clocked driver; a clocked monitor compares every
// result transaction with the value predicted at acceptance time.
// ----------------------------------------------------------------------------
module tb;

  localparam int FB     = 8;
  localparam int STEPS  = 16;
  localparam int LAT    = 22;
  localparam int IN_TW  = 72;
  localparam int OUT_TW = 40;
  localparam int N_RAND = 1750;

  // Operation code that the unit does not define; it yields an all-zero result.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [15:0] b_im, b_re, a_im, a_re;
    logic [2:0]         op;
  } operands_t;

  typedef struct packed {
    logic               same;
    logic [1:0]         order, status;
    logic signed [15:0] im, re;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;

  operands_t pending_q[$];
  answer_t   awaited_q[$];
  int        n_errors = 0;
  int        n_results = 0;
  bit        quiet_run = 1'b0;
  bit        hold_off = 1'b0;

  always #10 clk_i = ~clk_i;

  complex_arithmetic_unit_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  function automatic logic [IN_TW-1:0] pack_operands(operands_t o);
    return {{(IN_TW-67){1'b0}}, o.b_im, o.b_re, o.a_im, o.a_re, o.op};
  endfunction

  function automatic logic signed [15:0] clip(longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Product sum scaled back by 2^FB, rounding half away from zero.
  function automatic longint scale_round(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (1 << (FB-1))) >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  // Quotient * 2^FB, truncated toward zero; clamped early so it never grows.
  function automatic longint scaled_quotient(longint n, longint d);
    longint m, q, r;
    m = (n < 0) ? -n : n;
    q = m / d;
    r = m % d;
    if (q > 65536) q = 65536;
    for (int i = 0; i < FB; i++) begin
      r = r * 2;
      q = q * 2;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
      if (q > 65536) q = 65536;
    end
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC: magnitude in res re, binary-angle phase in res im.
  function automatic void polar_form(longint ar, longint ai, inout answer_t r,
                                     inout bit sat);
    longint x, y, dx, dy, mag;
    logic [31:0] z;
    x = ar * 256;
    y = ai * 256;
    z = 32'd0;
    if (ar == 0 && ai == 0) return;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += cau_pkg::atan_turn(i[4:0]);
      end else begin
        x -= dx;
        y += dy;
        z -= cau_pkg::atan_turn(i[4:0]);
      end
    end
    if (x < 0) x = 0;
    mag = (x * 636752 + (longint'(1) << 27)) >>> 28;
    r.re = clip(mag, sat);
    z = z + 32'h8000;
    r.im = z[31:16];
  endfunction

  function automatic answer_t predict_result(operands_t o);
    answer_t r;
    bit      sat;
    longint  ar, ai, br, bi, d, ma, mb;
    r = '0;
    sat = 1'b0;
    ar = o.a_re;
    ai = o.a_im;
    br = o.b_re;
    bi = o.b_im;
    case (o.op)
      cau_pkg::OP_ADD: begin
        r.re = clip(ar + br, sat);
        r.im = clip(ai + bi, sat);
      end
      cau_pkg::OP_SUB: begin
        r.re = clip(ar - br, sat);
        r.im = clip(ai - bi, sat);
      end
      cau_pkg::OP_MUL: begin
        r.re = clip(scale_round(ar*br - ai*bi), sat);
        r.im = clip(scale_round(ar*bi + ai*br), sat);
      end
      cau_pkg::OP_DIV: begin
        d = br*br + bi*bi;
        if (d == 0) begin
          r.status = cau_pkg::ST_DIVZ;
        end else begin
          r.re = clip(scaled_quotient(ar*br + ai*bi, d), sat);
          r.im = clip(scaled_quotient(ai*br - ar*bi, d), sat);
        end
      end
      cau_pkg::OP_CONJ: begin
        r.re = o.a_re;
        r.im = clip(-ai, sat);
      end
      cau_pkg::OP_POLAR: polar_form(ar, ai, r, sat);
      cau_pkg::OP_CMP: begin
        ma = ar*ar + ai*ai;
        mb = br*br + bi*bi;
        r.order = (ma < mb) ? cau_pkg::ORD_LT :
                  ((ma == mb) ? cau_pkg::ORD_EQ : cau_pkg::ORD_GT);
        r.same = (ar == br && ai == bi);
      end
      default: ;
    endcase
    if (sat && r.status == cau_pkg::ST_OK) r.status = cau_pkg::ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("ERROR result %0d: %s got %0d expected %0d", n_results, what, got, want);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Driver: valid is only lowered once the current transaction is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && !hold_off &&
            (quiet_run || $urandom_range(0, 99) >= 14)) begin
          s_tdata  <= pack_operands(pending_q[0]);
          s_tvalid <= 1'b1;
          pending_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= quiet_run || ($urandom_range(0, 99) >= 14);
    end
  end

  // Predict at input acceptance, check at output acceptance.
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      if (s_tvalid && s_tready)
        awaited_q.push_back(predict_result(operands_t'(s_tdata[66:0])));
      if (m_tvalid && m_tready) begin
        got = answer_t'(m_tdata[36:0]);
        n_results++;
        if (awaited_q.size() == 0) begin
          n_errors++;
          $display("ERROR result %0d arrived with nothing outstanding", n_results);
        end else begin
          want = awaited_q.pop_front();
          if (got.re != want.re) report_mismatch("res_re", got.re, want.re);
          if (got.im != want.im) report_mismatch("res_im", got.im, want.im);
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.order != want.order) report_mismatch("order", got.order, want.order);
          if (got.same != want.same) report_mismatch("same_value", got.same, want.same);
        end
      end
    end
  end

  function automatic operands_t make_op(logic [2:0] op, int ar, int ai, int br, int bi);
    operands_t o;
    o.op = op;
    o.a_re = ar[15:0];
    o.a_im = ai[15:0];
    o.b_re = br[15:0];
    o.b_im = bi[15:0];
    return o;
  endfunction

  initial begin
    operands_t o;
    // Directed: extremes, every op, divide by zero, zero polar, the unused
    // code and conjugating the most negative imaginary part.
    pending_q.push_back(make_op(cau_pkg::OP_ADD, 32767, -32768, 32767, -32768));
    pending_q.push_back(make_op(cau_pkg::OP_ADD, 256, 512, -256, 100));
    pending_q.push_back(make_op(cau_pkg::OP_SUB, -32768, 32767, 32767, -32768));
    pending_q.push_back(make_op(cau_pkg::OP_SUB, 1000, -7, 999, -7));
    pending_q.push_back(make_op(cau_pkg::OP_MUL, -32768, -32768, -32768, -32768));
    pending_q.push_back(make_op(cau_pkg::OP_MUL, 384, -128, 640, 256));
    pending_q.push_back(make_op(cau_pkg::OP_MUL, 1, 0, 128, 0));
    pending_q.push_back(make_op(cau_pkg::OP_DIV, 512, 256, 0, 0));
    pending_q.push_back(make_op(cau_pkg::OP_DIV, 32767, 32767, 1, 0));
    pending_q.push_back(make_op(cau_pkg::OP_DIV, 768, -256, 256, 256));
    pending_q.push_back(make_op(cau_pkg::OP_DIV, -32768, -32768, -32768, 32767));
    pending_q.push_back(make_op(cau_pkg::OP_CONJ, 100, -32768, 0, 0));
    pending_q.push_back(make_op(cau_pkg::OP_CONJ, -32768, 32767, 5, 5));
    pending_q.push_back(make_op(cau_pkg::OP_POLAR, 0, 0, 1, 1));
    pending_q.push_back(make_op(cau_pkg::OP_POLAR, -32768, 0, 0, 0));
    pending_q.push_back(make_op(cau_pkg::OP_POLAR, 32767, 32767, 0, 0));
    pending_q.push_back(make_op(cau_pkg::OP_POLAR, -32768, -32768, 0, 0));
    pending_q.push_back(make_op(cau_pkg::OP_POLAR, 0, -1, 0, 0));
    pending_q.push_back(make_op(cau_pkg::OP_CMP, 300, -400, 300, -400));
    pending_q.push_back(make_op(cau_pkg::OP_CMP, 300, 400, -500, 0));
    pending_q.push_back(make_op(cau_pkg::OP_CMP, -32768, 1, 1, 1));
    pending_q.push_back(make_op(OP_UNUSED, -1, -1, -1, -1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < N_RAND; n++) begin
      o.op   = ($urandom_range(0, 49) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
      o.a_re = rand_value();
      o.a_im = rand_value();
      if ($urandom_range(0, 9) == 0) begin
        o.b_re = o.a_re;
        o.b_im = o.a_im;
      end else begin
        o.b_re = ($urandom_range(0, 19) == 0) ? 16'sd0 : rand_value();
        o.b_im = ($urandom_range(0, 19) == 0) ? 16'sd0 : rand_value();
      end
      pending_q.push_back(o);
      // After a third: drain the pipeline completely, then run with no idling to the half.
      if (n == N_RAND/3) begin
        wait (pending_q.size() == 0);
        hold_off = 1'b1;
        wait (awaited_q.size() == 0 && !s_tvalid);
        hold_off = 1'b0;
        quiet_run = 1'b1;
      end
      if (n == N_RAND/2) begin
        wait (pending_q.size() == 0);
        quiet_run = 1'b0;
      end
    end

    wait (pending_q.size() == 0 && !s_tvalid && awaited_q.size() == 0);
    repeat (LAT + 10) @(posedge clk_i);
    $display("Covered %0d results over all seven ops, the unused code and saturation,",
             n_results);
    $display("divide by zero and polar of zero, with random gaps on both sides.");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", awaited_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
